// ===== design/esc_pkg.sv =====
// Shared constants, types and tables for the epoch seconds to calendar converter.
// Depends on nothing; used by epoch_seconds_to_calendar.

package esc_pkg;

   // Time of day.
   localparam int unsigned SecPerMinute = 60;
   localparam int unsigned SecPerHour   = 3600;
   localparam int unsigned SecPerDay    = 86400;

   // The day split works on seconds >> 7, then divides by the odd factor.
   localparam int unsigned DayShift     = 7;
   localparam int unsigned DayOddFactor = SecPerDay >> DayShift;

   // Calendar constants of the civil-from-days algorithm.
   localparam int unsigned ShiftToMarch = 719468;
   localparam int unsigned DaysPerEra   = 146097;
   localparam int unsigned LastEraDay   = DaysPerEra - 1;
   localparam int unsigned Days4Yr      = 1460;
   localparam int unsigned Days100Yr    = 36524;
   localparam int unsigned DaysPerYear  = 365;
   localparam int unsigned YearsPerEra  = 400;
   localparam int unsigned YearsPerCent = 100;
   localparam int unsigned MonthsMarchToDec = 10;

   // Bias that makes every day count positive: seconds get this many days
   // added, so the whole day split runs on unsigned words.
   localparam longint unsigned SecBiasDays = 64'd1 << 31;
   localparam logic [48:0] SecBias = 49'(SecBiasDays * SecPerDay);

   // The same bias rounded up to whole eras, folded with the March shift.
   localparam longint unsigned EraBiasCount = (SecBiasDays + DaysPerEra - 1) / DaysPerEra;
   localparam logic [32:0] EraBias =
      33'(EraBiasCount * DaysPerEra - SecBiasDays + ShiftToMarch);
   localparam logic [23:0] YearBias = 24'(EraBiasCount * YearsPerEra);

   // Rounded-up reciprocals; the shift is the input width plus the divisor's bits,
   // which keeps the product exact over the whole input range.
   typedef logic [19:0] recip_type;

   localparam int unsigned ShiftD4Yr   = 29;
   localparam int unsigned ShiftD100Yr = 34;
   localparam int unsigned ShiftD365   = 27;
   localparam int unsigned ShiftD100   = 16;
   localparam int unsigned ShiftD153   = 19;
   localparam int unsigned ShiftDHour  = 29;
   localparam int unsigned ShiftDMin   = 18;

   localparam recip_type RecipD4Yr =
      20'(((64'd1 << ShiftD4Yr) + Days4Yr - 1) / Days4Yr);
   localparam recip_type RecipD100Yr =
      20'(((64'd1 << ShiftD100Yr) + Days100Yr - 1) / Days100Yr);
   localparam recip_type RecipD365 =
      20'(((64'd1 << ShiftD365) + DaysPerYear - 1) / DaysPerYear);
   localparam recip_type RecipD100 =
      20'(((64'd1 << ShiftD100) + YearsPerCent - 1) / YearsPerCent);
   localparam recip_type RecipD153 = 20'(((64'd1 << ShiftD153) + 153 - 1) / 153);
   localparam recip_type RecipDHour =
      20'(((64'd1 << ShiftDHour) + SecPerHour - 1) / SecPerHour);
   localparam recip_type RecipDMin =
      20'(((64'd1 << ShiftDMin) + SecPerMinute - 1) / SecPerMinute);

   // Latency of one constant divider and of the whole converter.
   localparam int unsigned CdivLatency = 3;
   localparam int unsigned PipeLatency = 1 + 3 * CdivLatency + 8;

   // First day of each March-based month within the year.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] days;
      case (mp)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// ===== design/esc_cdiv.sv =====
// Pipelined floor division of an unsigned word by a constant, with remainder.
// Stand-alone: reciprocal multiply, back-multiply, one correction step.

module esc_cdiv #(
   parameter int unsigned XWidth    = 32,
   parameter int unsigned QWidth    = 16,
   parameter int unsigned RWidth    = 16,
   parameter int unsigned SideWidth = 1,
   parameter int unsigned Divisor   = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [XWidth-1:0]    in_x,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic [QWidth-1:0]    out_quot,
   output logic [RWidth-1:0]    out_rem,
   output logic [SideWidth-1:0] out_side
);

   // Truncated reciprocal: the estimate is the true quotient or one below it.
   localparam int unsigned RecipWidth = XWidth - $clog2(Divisor) + 1;
   localparam int unsigned ProdWidth  = XWidth + RecipWidth;
   localparam logic [RecipWidth-1:0] Recip = RecipWidth'((65'd1 << XWidth) / Divisor);

   logic                 v1_ff, v2_ff, v3_ff;
   logic [ProdWidth-1:0] prod_ff, prod_in;
   logic [XWidth-1:0]    x1_ff;
   logic [SideWidth-1:0] side1_ff, side2_ff, side3_ff;
   logic [QWidth-1:0]    q2_ff, q2_in, q3_ff, q3_in;
   logic [RWidth:0]      r2_ff, r2_in;
   logic [RWidth-1:0]    r3_ff, r3_in;
   logic [XWidth-1:0]    back, diff;

   // Stage 1: multiply by the reciprocal.
   assign prod_in = ProdWidth'(in_x) * ProdWidth'(Recip);

   // Stage 2: quotient estimate and the remainder it leaves (below twice the divisor).
   always_comb begin
      q2_in = prod_ff[XWidth +: QWidth];
      back  = XWidth'(XWidth'(q2_in) * XWidth'(Divisor));
      diff  = x1_ff - back;
      r2_in = diff[RWidth:0];
   end

   // Stage 3: one correction step.
   always_comb begin
      if (r2_ff >= (RWidth+1)'(Divisor)) begin
         q3_in = q2_ff + QWidth'(1);
         r3_in = RWidth'(r2_ff - (RWidth+1)'(Divisor));
      end else begin
         q3_in = q2_ff;
         r3_in = RWidth'(r2_ff);
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      x1_ff    <= in_x;
      side1_ff <= in_side;
      q2_ff    <= q2_in;
      r2_ff    <= r2_in;
      side2_ff <= side1_ff;
      q3_ff    <= q3_in;
      r3_ff    <= r3_in;
      side3_ff <= side2_ff;
   end

   assign out_valid = v3_ff;
   assign out_quot  = q3_ff;
   assign out_rem   = r3_ff;
   assign out_side  = side3_ff;

`ifndef SYNTHESIS
   // The estimate is never more than one divisor short.
   a_estimate_close: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (r2_ff < (RWidth+1)'(2 * Divisor)))
      else $error("esc_cdiv: quotient estimate off by more than one");

   // After correction the remainder is a true remainder.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (r3_ff < RWidth'(Divisor)))
      else $error("esc_cdiv: remainder not below divisor");

   // Every word that enters comes out at the output; none is lost in the pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##3 out_valid)
      else $error("esc_cdiv: word lost in the pipeline");
`endif

endmodule

// ===== design/epoch_seconds_to_calendar.sv =====
// Top level: converts signed epoch seconds into a Gregorian date and time of day.
// Depends on esc_pkg and on esc_cdiv for the three divisions by large constants.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+---------------------------
//   request  | req_epoch_seconds                      | start high while busy low
//   response | rsp_year/month/day/hour/minute/second  | rsp_strobe, one cycle each
//
// One word is taken every cycle. Each word passes through three pipelined constant
// dividers (by 675 twice for the day split, by 146097 for the era) and then through
// the date and time stages behind them.
// Reset clears only the valid bits; no payload register is reset.
// busy stays low: nothing in the pipeline waits, and results cannot be held off.

module epoch_seconds_to_calendar (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [47:0] req_epoch_seconds,
   output logic               rsp_strobe,
   output logic signed [23:0] rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second
);
   import esc_pkg::*;

   logic accept;

   // Stage 0: biased seconds, always positive.
   logic        s0_valid_ff;
   logic [48:0] s0_u_ff, s0_u_in;

   // First and second divisions by 675 (long division on 21-bit digits).
   logic        c1_valid, c2_valid, c3_valid;
   logic [11:0] c1_quot;
   logic [9:0]  c1_rem, c2_rem;
   logic [27:0] c1_side;
   logic [20:0] c2_quot;
   logic [18:0] c2_side;

   // Day count with era bias, and second of day.
   logic        s1_valid_ff;
   logic [31:0] s1_x_ff, s1_x_in;
   logic [16:0] s1_sod_ff, s1_sod_in;

   // Era division.
   logic [14:0] c3_quot;
   logic [17:0] c3_rem;
   logic [16:0] c3_side;

   // Date and time stages.
   logic        p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff;
   logic        p5_valid_ff, p6_valid_ff, p7_valid_ff;
   logic [17:0] p1_doe_ff, p2_doe_ff, p3_doe_ff, p4_doe_ff;
   logic [6:0]  p1_a_ff, p1_a_in;
   logic [2:0]  p1_b_ff, p1_b_in;
   logic        p1_c_ff;
   logic [23:0] p1_ybase_ff, p1_ybase_in, p2_ybase_ff, p3_ybase_ff;
   logic [23:0] p4_ybase_ff, p5_ybase_ff, p6_ybase_ff;
   logic [16:0] p1_sod_ff;
   logic [4:0]  p1_hour_ff, p1_hour_in, p2_hour_ff, p3_hour_ff, p4_hour_ff;
   logic [4:0]  p5_hour_ff, p6_hour_ff;
   logic [17:0] p2_t_ff, p2_t_in;
   logic [11:0] p2_hs_ff, p2_hs_in, p3_hs_ff;
   logic [8:0]  p3_yoe_ff, p3_yoe_in, p4_yoe_ff, p5_yoe_ff, p6_yoe_ff;
   logic [5:0]  p3_min_ff, p3_min_in, p4_min_ff, p5_min_ff, p6_min_ff;
   logic [17:0] p4_ydays_ff, p4_ydays_in;
   logic [5:0]  p4_sec_ff, p4_sec_in, p5_sec_ff, p6_sec_ff;
   logic [8:0]  p5_doy_ff, p5_doy_in, p6_doy_ff;
   logic [3:0]  p6_mp_ff, p6_mp_in;
   logic [23:0] p7_year_ff, p7_year_in;
   logic [3:0]  p7_month_ff, p7_month_in;
   logic [4:0]  p7_day_ff, p7_day_in;
   logic [4:0]  p7_hour_ff;
   logic [5:0]  p7_min_ff, p7_sec_ff;

   logic [39:0] prod_a, prod_b, prod_hour, prod_yoe;
   logic [31:0] prod_min, prod_y100, prod_mp;
   logic [2:0]  y100;
   logic [11:0] mp_num;
   logic [8:0]  day_wide;

   // The pipeline never stalls.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Sign-extend and add the day bias.
   assign s0_u_in = {req_epoch_seconds[47], req_epoch_seconds} + SecBias;

   // High digit of (seconds >> 7) divided by 675.
   esc_cdiv #(
      .XWidth(21), .QWidth(12), .RWidth(10), .SideWidth(28), .Divisor(DayOddFactor)
   ) u_cdiv_hi (
      .clock(clock), .reset(reset),
      .in_valid(s0_valid_ff), .in_x(s0_u_ff[48:28]), .in_side(s0_u_ff[27:0]),
      .out_valid(c1_valid), .out_quot(c1_quot), .out_rem(c1_rem), .out_side(c1_side)
   );

   // Low digit, with the high remainder brought down.
   esc_cdiv #(
      .XWidth(31), .QWidth(21), .RWidth(10), .SideWidth(19), .Divisor(DayOddFactor)
   ) u_cdiv_lo (
      .clock(clock), .reset(reset),
      .in_valid(c1_valid), .in_x({c1_rem, c1_side[27:7]}),
      .in_side({c1_quot, c1_side[6:0]}),
      .out_valid(c2_valid), .out_quot(c2_quot), .out_rem(c2_rem), .out_side(c2_side)
   );

   // Biased day count shifted to the March epoch and rounded to whole eras.
   always_comb begin
      s1_x_in   = 32'({c2_side[18:7], c2_quot} + EraBias);
      s1_sod_in = {c2_rem, c2_side[6:0]};
   end

   // Era and day of era.
   esc_cdiv #(
      .XWidth(32), .QWidth(15), .RWidth(18), .SideWidth(17), .Divisor(DaysPerEra)
   ) u_cdiv_era (
      .clock(clock), .reset(reset),
      .in_valid(s1_valid_ff), .in_x(s1_x_ff), .in_side(s1_sod_ff),
      .out_valid(c3_valid), .out_quot(c3_quot), .out_rem(c3_rem), .out_side(c3_side)
   );

   // Stage p1: leap corrections of the day of era, hour, year base of the era.
   always_comb begin
      prod_a      = 40'(c3_rem) * 40'(RecipD4Yr);
      prod_b      = 40'(c3_rem) * 40'(RecipD100Yr);
      prod_hour   = 40'(c3_side) * 40'(RecipDHour);
      p1_a_in     = 7'(prod_a >> ShiftD4Yr);
      p1_b_in     = 3'(prod_b >> ShiftD100Yr);
      p1_hour_in  = 5'(prod_hour >> ShiftDHour);
      p1_ybase_in = 24'(24'(c3_quot) * 24'(YearsPerEra)) - YearBias;
   end

   // Stage p2: day count without leap days, seconds within the hour.
   always_comb begin
      p2_t_in  = p1_doe_ff - 18'(p1_a_ff) + 18'(p1_b_ff) - 18'(p1_c_ff);
      p2_hs_in = 12'(p1_sod_ff - 17'(17'(p1_hour_ff) * 17'(SecPerHour)));
   end

   // Stage p3: year of era, minute.
   always_comb begin
      prod_yoe  = 40'(p2_t_ff) * 40'(RecipD365);
      prod_min  = 32'(p2_hs_ff) * 32'(RecipDMin);
      p3_yoe_in = 9'(prod_yoe >> ShiftD365);
      p3_min_in = 6'(prod_min >> ShiftDMin);
   end

   // Stage p4: days before this year within the era, second.
   always_comb begin
      prod_y100   = 32'(p3_yoe_ff) * 32'(RecipD100);
      y100        = 3'(prod_y100 >> ShiftD100);
      p4_ydays_in = 18'(18'(p3_yoe_ff) * 18'(DaysPerYear)) + 18'(p3_yoe_ff >> 2)
                    - 18'(y100);
      p4_sec_in   = 6'(p3_hs_ff - 12'(12'(p3_min_ff) * 12'(SecPerMinute)));
   end

   // Stage p5: day of the March-based year.
   assign p5_doy_in = 9'(p4_doe_ff - p4_ydays_ff);

   // Stage p6: March-based month.
   always_comb begin
      mp_num   = 12'(12'(p5_doy_ff) * 12'd5) + 12'd2;
      prod_mp  = 32'(mp_num) * 32'(RecipD153);
      p6_mp_in = 4'(prod_mp >> ShiftD153);
   end

   // Stage p7: day of month, civil month, and the year (January and February
   // belong to the next civil year).
   always_comb begin
      day_wide  = p6_doy_ff - month_start(p6_mp_ff) + 9'd1;
      p7_day_in = day_wide[4:0];
      if (p6_mp_ff < 4'(MonthsMarchToDec)) begin
         p7_month_in = p6_mp_ff + 4'd3;
         p7_year_in  = p6_ybase_ff + 24'(p6_yoe_ff);
      end else begin
         p7_month_in = p6_mp_ff - 4'd9;
         p7_year_in  = p6_ybase_ff + 24'(p6_yoe_ff) + 24'd1;
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
         p6_valid_ff <= 1'b0;
         p7_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
         s1_valid_ff <= c2_valid;
         p1_valid_ff <= c3_valid;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
         p6_valid_ff <= p5_valid_ff;
         p7_valid_ff <= p6_valid_ff;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      s0_u_ff     <= s0_u_in;
      s1_x_ff     <= s1_x_in;
      s1_sod_ff   <= s1_sod_in;

      p1_doe_ff   <= c3_rem;
      p1_a_ff     <= p1_a_in;
      p1_b_ff     <= p1_b_in;
      p1_c_ff     <= (c3_rem == 18'(LastEraDay));
      p1_ybase_ff <= p1_ybase_in;
      p1_sod_ff   <= c3_side;
      p1_hour_ff  <= p1_hour_in;

      p2_t_ff     <= p2_t_in;
      p2_hs_ff    <= p2_hs_in;
      p2_doe_ff   <= p1_doe_ff;
      p2_ybase_ff <= p1_ybase_ff;
      p2_hour_ff  <= p1_hour_ff;

      p3_yoe_ff   <= p3_yoe_in;
      p3_min_ff   <= p3_min_in;
      p3_hs_ff    <= p2_hs_ff;
      p3_doe_ff   <= p2_doe_ff;
      p3_ybase_ff <= p2_ybase_ff;
      p3_hour_ff  <= p2_hour_ff;

      p4_ydays_ff <= p4_ydays_in;
      p4_sec_ff   <= p4_sec_in;
      p4_doe_ff   <= p3_doe_ff;
      p4_ybase_ff <= p3_ybase_ff;
      p4_yoe_ff   <= p3_yoe_ff;
      p4_hour_ff  <= p3_hour_ff;
      p4_min_ff   <= p3_min_ff;

      p5_doy_ff   <= p5_doy_in;
      p5_ybase_ff <= p4_ybase_ff;
      p5_yoe_ff   <= p4_yoe_ff;
      p5_hour_ff  <= p4_hour_ff;
      p5_min_ff   <= p4_min_ff;
      p5_sec_ff   <= p4_sec_ff;

      p6_mp_ff    <= p6_mp_in;
      p6_doy_ff   <= p5_doy_ff;
      p6_ybase_ff <= p5_ybase_ff;
      p6_yoe_ff   <= p5_yoe_ff;
      p6_hour_ff  <= p5_hour_ff;
      p6_min_ff   <= p5_min_ff;
      p6_sec_ff   <= p5_sec_ff;

      p7_year_ff  <= p7_year_in;
      p7_month_ff <= p7_month_in;
      p7_day_ff   <= p7_day_in;
      p7_hour_ff  <= p6_hour_ff;
      p7_min_ff   <= p6_min_ff;
      p7_sec_ff   <= p6_sec_ff;
   end

   // Result ports.
   assign rsp_strobe = p7_valid_ff;
   assign rsp_year   = signed'(p7_year_ff);
   assign rsp_month  = p7_month_ff;
   assign rsp_day    = p7_day_ff;
   assign rsp_hour   = p7_hour_ff;
   assign rsp_minute = p7_min_ff;
   assign rsp_second = p7_sec_ff;

`ifndef SYNTHESIS
   // Every accepted word gives exactly one result, a fixed time later.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##PipeLatency rsp_strobe)
      else $error("epoch_seconds_to_calendar: result missing");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##PipeLatency !rsp_strobe)
      else $error("epoch_seconds_to_calendar: result without a request");

   // Every field of a result lies in its calendar range.
   a_field_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1
                      && rsp_hour <= 5'd23 && rsp_minute <= 6'd59
                      && rsp_second <= 6'd59))
      else $error("epoch_seconds_to_calendar: field out of range");

   // Short months never run past day 30, and February never past day 29.
   a_short_month: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_month != 4'd2 || rsp_day <= 5'd29)
                      && ((rsp_month != 4'd4 && rsp_month != 4'd6
                           && rsp_month != 4'd9 && rsp_month != 4'd11)
                          || rsp_day <= 5'd30)))
      else $error("epoch_seconds_to_calendar: day past end of month");
`endif

endmodule
